// File: hdl/sgm_pkg.sv
// Shared types and constants of the Sobel gradient magnitude block.
// Used by the front end, the entry queue, the back end and the top level.
package sgm_pkg;

	localparam int PIX_W = 8;
	localparam int ROW_W = 13;
	localparam logic [ROW_W-1:0] ROW_CAP = 13'h1FFF;
	localparam int MAG_CLAMP = 65025;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// One window of nine pixels ready for the gradient, plus its frame-end mark.
	typedef struct packed {
		logic [8:0][PIX_W-1:0] win;
		logic                  last;
	} sgm_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sgm_q_status_t;

endpackage

// File: hdl/sobel_gradient_magnitude.sv
// Sobel gradient magnitude over a raster stream of 8-bit grey pixels.
// Throughput: one pixel per cycle unless the queue is full; each line store reads and writes once.
// A result's window is queued when the pixel width+1 after its centre leaves front-end stage 1.
// Reset clears the position counters, the window, the queue and all valid flags;
// the line stores are not cleared. Config registers reset to 640 x 480, width at most MAX_WIDTH.
// Depends on sgm_pkg, sgm_front, sgm_queue and sgm_back.
module sobel_gradient_magnitude import sgm_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [ROW_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              frame_start,
	input  logic              pad,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        magnitude,
	output logic              last
);

	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int RST_WIDTH = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [11:0]      wr_width;

	logic            q_push;
	logic            q_pop;
	sgm_entry_t      q_in;
	sgm_entry_t      q_out;
	sgm_q_status_t   q_stat;

	assign cfg_ready = 1'b1;
	assign wr_width  = cfg_data[11:0];

	// Registers hold the effective size: width in 3..MAX_WIDTH, height at least 3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(RST_WIDTH);
			height_q <= ROW_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					priority if (wr_width < 12'd3) begin
						width_q <= WID_W'(3);
					end else if (32'(wr_width) > MAX_WIDTH) begin
						width_q <= WID_W'(MAX_WIDTH);
					end else begin
						width_q <= WID_W'(wr_width);
					end
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= (cfg_data < ROW_W'(3)) ? ROW_W'(3) : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	sgm_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.width      (width_q),
		.height     (height_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.frame_start(frame_start),
		.pad        (pad),
		.q_push     (q_push),
		.q_entry    (q_in),
		.q_stat     (q_stat)
	);

	sgm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_in),
		.pop       (q_pop),
		.pop_entry (q_out),
		.stat      (q_stat)
	);

	sgm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_entry  (q_out),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.magnitude(magnitude),
		.last     (last)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("Request pushed into a full queue.");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("Request popped from an empty queue.");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_stat.full)
		else $error("Input stalled while the queue had room.");

endmodule

// File: hdl/sgm_queue.sv
// Short request queue between the front end and the back end.
// Depends on sgm_pkg for the entry type and the queue depth.
module sgm_queue import sgm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sgm_entry_t    push_entry,
	input  logic          pop,
	output sgm_entry_t    pop_entry,
	output sgm_q_status_t stat
);

	sgm_entry_t           mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign stat.full  = count_q == Q_CNT_W'(Q_DEPTH);
	assign stat.empty = count_q == '0;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

// File: hdl/sgm_front.sv
// Front end: accepts pixels, tracks input and output positions, keeps the
// two line stores and the 3x3 window, and queues one window per result.
// Depends on sgm_pkg.
module sgm_front import sgm_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_WIDTH + 1)-1:0] width,
	input  logic [ROW_W-1:0]                 height,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [PIX_W-1:0]                 pixel,
	input  logic                             frame_start,
	input  logic                             pad,
	output logic                             q_push,
	output sgm_entry_t                       q_entry,
	input  sgm_q_status_t                    q_stat
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMP_W = COL_W + 1;

	function automatic logic [ROW_W-1:0] row_inc(logic [ROW_W-1:0] r);
		return (r == ROW_CAP) ? r : r + ROW_W'(1);
	endfunction

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic [8:0][PIX_W-1:0] win_q;

	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1;
	logic             border_s1;
	logic             last_s1;
	logic [PIX_W-1:0] top_rd_s1;
	logic [PIX_W-1:0] mid_rd_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_top_s1;
	logic [PIX_W-1:0] fwd_mid_s1;

	logic             acc;
	logic             s1_adv;
	logic [PIX_W-1:0] pix_in;
	logic [COL_W-1:0] c0, c1, col_d;
	logic [ROW_W-1:0] r0, r1, row_d;
	logic [CMP_W-1:0] cn;
	logic             lag;
	logic [COL_W-1:0] oc0, oc1, ocol_d;
	logic [ROW_W-1:0] or0, or1, orow_d;
	logic [CMP_W-1:0] ocn;
	logic [CMP_W-1:0] w_ext;
	logic [CMP_W-1:0] wm1_ext;
	logic [ROW_W-1:0] hm1;
	logic             emit;
	logic             border;
	logic             last_pix;
	logic [PIX_W-1:0] top_eff;
	logic [PIX_W-1:0] mid_eff;
	logic [8:0][PIX_W-1:0] win_next;

	assign s1_adv   = valid_s1 && !q_stat.full;
	assign in_ready = !valid_s1 || !q_stat.full;
	assign acc      = in_valid && in_ready;
	assign pix_in   = pad ? '0 : pixel;
	assign w_ext    = CMP_W'(width);
	assign wm1_ext  = w_ext - CMP_W'(1);
	assign hm1      = height - ROW_W'(1);

	always_comb begin
		c0  = frame_start ? '0 : in_col_q;
		r0  = frame_start ? '0 : in_row_q;
		oc0 = frame_start ? '0 : out_col_q;
		or0 = frame_start ? '0 : out_row_q;

		if (CMP_W'(c0) >= w_ext) begin
			c1 = '0;
			r1 = row_inc(r0);
		end else begin
			c1 = c0;
			r1 = r0;
		end
		lag = (r1 >= ROW_W'(2)) || (r1 == ROW_W'(1) && c1 != '0);

		cn = CMP_W'(c1) + CMP_W'(1);
		if (cn >= w_ext) begin
			col_d = '0;
			row_d = row_inc(r1);
		end else begin
			col_d = cn[COL_W-1:0];
			row_d = r1;
		end

		if (CMP_W'(oc0) >= w_ext) begin
			oc1 = '0;
			or1 = row_inc(or0);
		end else begin
			oc1 = oc0;
			or1 = or0;
		end
		emit     = lag && (or1 < height);
		border   = (or1 == '0) || (or1 == hm1) || (oc1 == '0) || (CMP_W'(oc1) == wm1_ext);
		last_pix = (or1 == hm1) && (CMP_W'(oc1) == wm1_ext);

		ocn = CMP_W'(oc1) + CMP_W'(1);
		priority if (!lag) begin
			ocol_d = oc0;
			orow_d = or0;
		end else if (!emit) begin
			ocol_d = oc1;
			orow_d = or1;
		end else if (ocn >= w_ext) begin
			ocol_d = '0;
			orow_d = row_inc(or1);
		end else begin
			ocol_d = ocn[COL_W-1:0];
			orow_d = or1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (acc) begin
				in_col_q  <= col_d;
				in_row_q  <= row_d;
				out_col_q <= ocol_d;
				out_row_q <= orow_d;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// The request in stage 1 writes the same column that a new request may read
	// in the same cycle; its values are forwarded.
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1     <= pix_in;
			col_s1     <= c1;
			emit_s1    <= emit;
			border_s1  <= border;
			last_s1    <= last_pix;
			fwd_s1     <= valid_s1 && (col_s1 == c1);
			fwd_top_s1 <= mid_eff;
			fwd_mid_s1 <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			top_rd_s1 <= upper_mem[c1];
		end
		if (s1_adv) begin
			upper_mem[col_s1] <= mid_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mid_rd_s1 <= middle_mem[c1];
		end
		if (s1_adv) begin
			middle_mem[col_s1] <= pix_s1;
		end
	end

	assign top_eff = fwd_s1 ? fwd_top_s1 : top_rd_s1;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r * 3]     = win_q[r * 3 + 1];
			win_next[r * 3 + 1] = win_q[r * 3 + 2];
		end
		win_next[2] = top_eff;
		win_next[5] = mid_eff;
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= win_next;
		end
	end

	assign q_push        = s1_adv && emit_s1;
	assign q_entry.win   = border_s1 ? '0 : win_next;
	assign q_entry.last  = last_s1;

endmodule

// File: hdl/sgm_back.sv
// Back end: Sobel sums, squared magnitude with clamp, and a pipelined
// two-bits-per-stage integer square root into the output register.
// Depends on sgm_pkg.
module sgm_back import sgm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  sgm_entry_t    q_entry,
	input  sgm_q_status_t q_stat,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    magnitude,
	output logic          last
);

	typedef struct packed {
		logic [10:0] rem;
		logic [7:0]  root;
	} sqrt_t;

	function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] bits);
		sqrt_t       nxt;
		logic [10:0] acc;
		logic [10:0] trial;
		acc   = {cur.rem[8:0], bits};
		trial = {1'b0, cur.root, 2'b01};
		if (acc >= trial) begin
			nxt.rem  = acc - trial;
			nxt.root = {cur.root[6:0], 1'b1};
		end else begin
			nxt.rem  = acc;
			nxt.root = {cur.root[6:0], 1'b0};
		end
		return nxt;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic l_s1, l_s2, l_s3, l_s4, l_s5, l_s6;
	logic signed [10:0] gx_s1, gy_s1;
	logic [19:0] sqx_s2, sqy_s2;
	logic [15:0] val_s3;
	sqrt_t       sq_s4, sq_s5, sq_s6;
	logic [11:0] rest_s4;
	logic [7:0]  rest_s5;
	logic [3:0]  rest_s6;
	logic        out_valid_q;
	logic [7:0]  magnitude_q;
	logic        last_q;

	logic [9:0]  sum_r, sum_l, sum_t, sum_b;
	logic signed [10:0] gx_d, gy_d;
	logic signed [21:0] px, py;
	logic [20:0] ssum;
	logic [15:0] val_d;
	sqrt_t       sq_fin;

	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && !q_stat.empty;

	always_comb begin
		sum_r = 10'(q_entry.win[2]) + {1'b0, q_entry.win[5], 1'b0} + 10'(q_entry.win[8]);
		sum_l = 10'(q_entry.win[0]) + {1'b0, q_entry.win[3], 1'b0} + 10'(q_entry.win[6]);
		sum_t = 10'(q_entry.win[0]) + {1'b0, q_entry.win[1], 1'b0} + 10'(q_entry.win[2]);
		sum_b = 10'(q_entry.win[6]) + {1'b0, q_entry.win[7], 1'b0} + 10'(q_entry.win[8]);
		gx_d  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
		gy_d  = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
		px    = 22'(gx_s1) * 22'(gx_s1);
		py    = 22'(gy_s1) * 22'(gy_s1);
		ssum  = 21'(sqx_s2) + 21'(sqy_s2);
		val_d = (ssum > 21'(MAG_CLAMP)) ? 16'(MAG_CLAMP) : ssum[15:0];
	end

	assign sq_fin = sqrt_step(sqrt_step(sq_s6, rest_s6[3:2]), rest_s6[1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= q_pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s1       <= gx_d;
			gy_s1       <= gy_d;
			l_s1        <= q_entry.last;
			sqx_s2      <= px[19:0];
			sqy_s2      <= py[19:0];
			l_s2        <= l_s1;
			val_s3      <= val_d;
			l_s3        <= l_s2;
			sq_s4       <= sqrt_step(sqrt_step('0, val_s3[15:14]), val_s3[13:12]);
			rest_s4     <= val_s3[11:0];
			l_s4        <= l_s3;
			sq_s5       <= sqrt_step(sqrt_step(sq_s4, rest_s4[11:10]), rest_s4[9:8]);
			rest_s5     <= rest_s4[7:0];
			l_s5        <= l_s4;
			sq_s6       <= sqrt_step(sqrt_step(sq_s5, rest_s5[7:6]), rest_s5[5:4]);
			rest_s6     <= rest_s5[3:0];
			l_s6        <= l_s5;
			magnitude_q <= sq_fin.root;
			last_q      <= l_s6;
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = magnitude_q;
	assign last      = last_q;

endmodule
